// ----- rtl/ptq_pkg.sv -----
// shared types and constants of the periodic timer queue
package ptq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);
  localparam int PERIOD_W    = 20;
  localparam int TAG_W       = 64;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_IDLE      = 3'd5
  } status_e;

  typedef struct packed {
    op_e                 opcode;
    logic [PERIOD_W-1:0] delay;
    logic [PERIOD_W-1:0] interval;
    logic [3:0]          timer_id;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot_id;
    logic       last;
  } rsp_t;

  // compare unit verdict on one slot
  typedef struct packed {
    logic due;
    logic better;
  } cmp_t;

endpackage

// ----- rtl/ptq_ram.sv -----
// generic single write port ram with registered read
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ptq_cmp.sv -----
// shared age and order comparator used by the expiry scan
module ptq_cmp import ptq_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] deadline,
  input  logic [TAG_W-1:0]     tag,
  input  logic                 best_found,
  input  logic [TIME_BITS-1:0] best_age,
  input  logic [TAG_W-1:0]     best_tag,
  output logic [TIME_BITS-1:0] age,
  output cmp_t                 verdict
);

  assign age            = now - deadline;
  assign verdict.due    = ~age[TIME_BITS-1];
  assign verdict.better = ~best_found || (age > best_age) ||
                          ((age == best_age) && (tag < best_tag));

endmodule

// ----- rtl/periodic_timer_queue.sv -----
// top level of the periodic timer queue: sequencer, slot flags and result register
//
// Holds up to TIMER_SLOTS timers in one slot ram (deadline, period, order tag);
// valid flags live in flip-flops and clear at reset, so no clearing pass is run.
// One item is taken at a time and req_ready is high only while the sequencer is
// idle; a finished result waits in the output register without blocking the next
// item. An unused opcode returns no result; add finds a free slot by walking the
// valid flags one slot per cycle. A tick runs one scan round per expired timer and
// a closing round that finds none, unless the limit of 16 results ends it first;
// in each round a single comparator walks the slot ram one entry per cycle through
// its one read port and picks the next timer by age, then tag. A stall on rsp_ready
// holds the sequencer wherever a result is handed over.
module periodic_timer_queue import ptq_pkg::*; #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SLOT_W  = $clog2(TIMER_SLOTS);
  localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
  localparam int ENTRY_W = TIME_BITS + PERIOD_W + TAG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [TIME_BITS-1:0]   now;
  logic [TAG_W-1:0]       next_tag;
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [TIMER_SLOTS-1:0] taken;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_vld;
  logic [SLOT_W-1:0]      rd_slot;
  logic                   best_found;
  logic [SLOT_W-1:0]      best_slot;
  logic [TIME_BITS-1:0]   best_age;
  logic [TAG_W-1:0]       best_tag;
  logic [PERIOD_W-1:0]    best_period;
  logic [SLOT_W-1:0]      prev_slot;
  logic                   have_prev;
  logic [RES_W-1:0]       n_res;
  req_t                   req_q;
  rsp_t                   res;

  logic [TAG_W-1:0]       tag_next;
  logic                   out_free;
  logic                   cnt_end;
  logic [SLOT_W-1:0]      cnt_idx;
  logic                   need_emit;
  logic                   round_go;
  logic                   rsp_load;
  logic [SLOT_W+3:0]      id_wide;
  logic                   id_in_range;
  logic [SLOT_W-1:0]      id_idx;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [TIME_BITS-1:0]   rd_deadline;
  logic [PERIOD_W-1:0]    rd_period;
  logic [TAG_W-1:0]       rd_tag;
  logic [TIME_BITS-1:0]   cmp_age;
  cmp_t                   verdict;

  function automatic logic [TIME_BITS-1:0] add_time(input logic [TIME_BITS-1:0] t,
                                                    input logic [PERIOD_W-1:0]  d);
    logic [TIME_BITS+PERIOD_W-1:0] sum;
    sum = {{PERIOD_W{1'b0}}, t} + {{TIME_BITS{1'b0}}, d};
    return sum[TIME_BITS-1:0];
  endfunction

  function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

  assign req_ready   = (state == S_IDLE);
  assign tag_next    = next_tag + TAG_W'(1);
  assign out_free    = ~rsp_valid | rsp_ready;
  assign cnt_end     = (cnt == CNT_W'(TIMER_SLOTS));
  assign cnt_idx     = cnt[SLOT_W-1:0];
  assign need_emit   = have_prev | ~best_found;
  assign round_go    = ~need_emit | out_free;
  assign rsp_load    = out_free & (((state == S_ROUND) & need_emit) |
                                   (state == S_FINAL) | (state == S_EMIT));
  assign id_wide     = {{SLOT_W{1'b0}}, req.timer_id};
  assign id_in_range = (id_wide < (SLOT_W+4)'(TIMER_SLOTS));
  assign id_idx      = id_wide[SLOT_W-1:0];

  assign rd_tag      = ram_rdata[TAG_W-1:0];
  assign rd_period   = ram_rdata[TAG_W +: PERIOD_W];
  assign rd_deadline = ram_rdata[TAG_W+PERIOD_W +: TIME_BITS];

  // slot ram write: new timer on add, re-arm at the end of a round
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_slot;
    ram_wdata = {add_time(now, best_period), best_period, tag_next};
    if (state == S_ADD && !cnt_end && !slot_valid[cnt_idx]) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_idx;
      ram_wdata = {add_time(now, req_q.delay), req_q.interval, tag_next};
    end else if (state == S_ROUND && round_go && best_found && best_period != '0) begin
      ram_we = 1'b1;
    end
  end

  ptq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_idx),
    .rdata (ram_rdata)
  );

  ptq_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .now        (now),
    .deadline   (rd_deadline),
    .tag        (rd_tag),
    .best_found (best_found),
    .best_age   (best_age),
    .best_tag   (best_tag),
    .age        (cmp_age),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      next_tag   <= '0;
      slot_valid <= '0;
      taken      <= '0;
      rsp_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      best_found <= 1'b0;
      have_prev  <= 1'b0;
      n_res      <= '0;
      cnt        <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            unique case (req.opcode)
              OP_TICK: begin
                now        <= now + TIME_BITS'(1);
                taken      <= '0;
                n_res      <= '0;
                have_prev  <= 1'b0;
                cnt        <= '0;
                rd_vld     <= 1'b0;
                best_found <= 1'b0;
                state      <= S_SCAN;
              end
              OP_ADD: begin
                cnt   <= '0;
                state <= S_ADD;
              end
              OP_CANCEL: begin
                if (id_in_range && slot_valid[id_idx]) begin
                  slot_valid[id_idx] <= 1'b0;
                  res <= '{status: ST_CANCELLED, slot_id: req.timer_id, last: 1'b1};
                end else begin
                  res <= '{status: ST_UNKNOWN, slot_id: req.timer_id, last: 1'b1};
                end
                state <= S_EMIT;
              end
              OP_NOP: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          if (cnt_end) begin
            res   <= '{status: ST_FULL, slot_id: 4'd0, last: 1'b1};
            state <= S_EMIT;
          end else if (!slot_valid[cnt_idx]) begin
            slot_valid[cnt_idx] <= 1'b1;
            next_tag            <= tag_next;
            res   <= '{status: ST_ADDED, slot_id: slot4(cnt_idx), last: 1'b1};
            state <= S_EMIT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (!cnt_end) begin
            cnt     <= cnt + CNT_W'(1);
            rd_vld  <= 1'b1;
            rd_slot <= cnt_idx;
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= S_ROUND;
            end
          end
          if (rd_vld && slot_valid[rd_slot] && !taken[rd_slot] &&
              verdict.due && verdict.better) begin
            best_found  <= 1'b1;
            best_slot   <= rd_slot;
            best_age    <= cmp_age;
            best_tag    <= rd_tag;
            best_period <= rd_period;
          end
        end
        S_ROUND: begin
          if (round_go) begin
            if (best_found) begin
              taken[best_slot] <= 1'b1;
              if (best_period == '0) begin
                slot_valid[best_slot] <= 1'b0;
              end else begin
                next_tag <= tag_next;
              end
              if (have_prev) begin
                rsp <= '{status: ST_EXPIRED, slot_id: slot4(prev_slot), last: 1'b0};
              end
              prev_slot <= best_slot;
              have_prev <= 1'b1;
              if (n_res == RES_W'(MAX_RESULTS - 1)) begin
                state <= S_FINAL;
              end else begin
                n_res      <= n_res + RES_W'(1);
                cnt        <= '0;
                rd_vld     <= 1'b0;
                best_found <= 1'b0;
                state      <= S_SCAN;
              end
            end else begin
              if (have_prev) begin
                rsp <= '{status: ST_EXPIRED, slot_id: slot4(prev_slot), last: 1'b1};
              end else begin
                rsp <= '{status: ST_IDLE, slot_id: 4'd0, last: 1'b1};
              end
              state <= S_IDLE;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            rsp   <= '{status: ST_EXPIRED, slot_id: slot4(prev_slot), last: 1'b1};
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
